FILE: rtl/core/mltu_pkg.sv
// ----------------------------------------------------------------------------
// mltu_pkg
// Shared types and constants of the device address table.
// ----------------------------------------------------------------------------
package mltu_pkg;

  // widths that cover the largest supported table (1024 entries)
  localparam int unsigned SlotMaxW = 10;
  localparam int unsigned CntMaxW  = 11;

  localparam int unsigned AddrW = 48;
  localparam int unsigned TimeW = 32;
  localparam int unsigned SeenW = 16;

  localparam logic [1:0] SrcBoth = 2'd2;
  localparam logic [SeenW-1:0] SeenMax = '1;

  localparam logic [7:0]       FloorReset  = 8'h9C;  // -100 dBm
  localparam logic [TimeW-1:0] ExpiryReset = 32'd60000;

  typedef enum logic {
    CfgRssiFloor = 1'b0,
    CfgExpiryMs  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    KindSighting = 1'b0,
    KindSweep    = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

  // search token that walks the cell chain
  typedef struct packed {
    logic                active;
    logic                kind;
    logic [AddrW-1:0]    addr;
    logic                src;
    logic [TimeW-1:0]    now;
    logic                hit;
    logic [SlotMaxW-1:0] hit_slot;
    logic [1:0]          hit_src;
    logic [SeenW-1:0]    hit_cnt;
    logic                free_found;
    logic [SlotMaxW-1:0] free_slot;
    logic                best_have;
    logic [TimeW-1:0]    best_age;
    logic [SlotMaxW-1:0] best_slot;
    logic [CntMaxW-1:0]  removed;
  } tok_t;

  // new entry write, broadcast to all cells
  typedef struct packed {
    logic                en;
    logic [SlotMaxW-1:0] slot;
    logic [AddrW-1:0]    addr;
    logic [TimeW-1:0]    now;
    logic                src;
  } wr_t;

  typedef struct packed {
    logic       accepted;
    logic       was_new;
    logic       evicted;
    logic [5:0] slot;
    logic [1:0] src;
    logic [15:0] cnt;
    logic [6:0] entry_count;
    logic [6:0] removed;
  } res_t;

endpackage

FILE: rtl/core/mac_table_lru_upsert_top.sv
// ----------------------------------------------------------------------------
// mac_table_lru_upsert_top
// Device address table with least-recently-seen replacement and aging.
// ----------------------------------------------------------------------------
// A sighting or sweep enters a chain of TableEntries cells, one entry per cell;
// a search token moves one cell per clock; the result is registered when the
// token leaves the last cell. A sighting below the strength floor skips the
// chain and its result is registered directly. The result sits in an output
// register, so the next item is taken while it waits. No clearing is needed
// after reset.
module mac_table_lru_upsert_top #(
  parameter int unsigned TableEntries = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [47:0] address_i,
  input  logic        link_source_i,
  input  logic signed [7:0] signal_dbm_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic        was_new_o,
  output logic        evicted_o,
  output logic [5:0]  slot_o,
  output logic [1:0]  merged_source_o,
  output logic [15:0] seen_count_o,
  output logic [6:0]  entry_count_o,
  output logic [6:0]  removed_count_o
);

  localparam int unsigned CntW = $clog2(TableEntries + 1);

  logic signed [7:0]  floor_q;
  logic [31:0]        expiry_q;
  logic [CntW-1:0]    total_q, total_d;
  mltu_pkg::state_e   state_q, state_d;
  mltu_pkg::res_t     res_q, res_d;
  mltu_pkg::res_t     out_q;
  logic               out_valid_q;
  mltu_pkg::tok_t     tok [TableEntries+1];
  mltu_pkg::tok_t     tail;
  mltu_pkg::wr_t      wr;
  logic               in_fire, reject, out_load;
  logic [mltu_pkg::CntMaxW-1:0] tot_ext;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q  <= mltu_pkg::FloorReset;
      expiry_q <= mltu_pkg::ExpiryReset;
    end else if (cfg_we_i) begin
      unique case (mltu_pkg::cfg_idx_e'(cfg_index_i))
        mltu_pkg::CfgRssiFloor: floor_q  <= cfg_data_i[7:0];
        mltu_pkg::CfgExpiryMs:  expiry_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != mltu_pkg::StIdle);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign reject     = (kind_i == mltu_pkg::KindSighting) && (signal_dbm_i < floor_q);
  assign out_load   = (state_q == mltu_pkg::StDone) && (!out_valid_q || !out_stall_i);
  assign tail       = tok[TableEntries];

  // token launch into the head of the chain
  always_comb begin
    tok[0]        = '0;
    tok[0].active = in_fire && !reject;
    tok[0].kind   = kind_i;
    tok[0].addr   = address_i;
    tok[0].src    = link_source_i;
    tok[0].now    = now_ms_i;
  end

  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    mltu_cell #(.Idx(g)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .expiry_i (expiry_q),
      .tok_i    (tok[g]),
      .wr_i     (wr),
      .tok_o    (tok[g+1])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mltu_pkg::StIdle: begin
        if (in_fire) state_d = reject ? mltu_pkg::StDone : mltu_pkg::StScan;
      end
      mltu_pkg::StScan: begin
        if (tail.active) state_d = mltu_pkg::StDone;
      end
      mltu_pkg::StDone: begin
        if (out_load) state_d = mltu_pkg::StIdle;
      end
      default: state_d = mltu_pkg::StIdle;
    endcase
  end

  // result of a rejected sighting, and result and table write when the token leaves the chain
  always_comb begin
    res_d   = res_q;
    total_d = total_q;
    wr      = '0;
    wr.addr = tail.addr;
    wr.now  = tail.now;
    wr.src  = tail.src;
    tot_ext = '0;
    unique case (state_q)
      mltu_pkg::StIdle: begin
        if (in_fire && reject) begin
          res_d = '0;
          tot_ext = mltu_pkg::CntMaxW'(total_q);
          res_d.entry_count = tot_ext[6:0];
        end
      end
      mltu_pkg::StScan: begin
        if (tail.active) begin
          res_d = '0;
          if (tail.kind == mltu_pkg::KindSweep) begin
            total_d = total_q - tail.removed[CntW-1:0];
            res_d.removed = tail.removed[6:0];
          end else if (tail.hit) begin
            res_d.accepted = 1'b1;
            res_d.slot     = tail.hit_slot[5:0];
            res_d.src      = tail.hit_src;
            res_d.cnt      = tail.hit_cnt;
          end else begin
            wr.en   = 1'b1;
            wr.slot = tail.free_found ? tail.free_slot : tail.best_slot;
            if (tail.free_found) total_d = total_q + 1'b1;
            res_d.accepted = 1'b1;
            res_d.was_new  = 1'b1;
            res_d.evicted  = !tail.free_found;
            res_d.slot     = wr.slot[5:0];
            res_d.src      = {1'b0, tail.src};
            res_d.cnt      = 16'd1;
          end
          tot_ext = mltu_pkg::CntMaxW'(total_d);
          res_d.entry_count = tot_ext[6:0];
        end
      end
      mltu_pkg::StDone: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mltu_pkg::StIdle;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) out_q <= res_q;
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = out_q.accepted;
  assign was_new_o       = out_q.was_new;
  assign evicted_o       = out_q.evicted;
  assign slot_o          = out_q.slot;
  assign merged_source_o = out_q.src;
  assign seen_count_o    = out_q.cnt;
  assign entry_count_o   = out_q.entry_count;
  assign removed_count_o = out_q.removed;

  a_tail_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.active |-> state_q == mltu_pkg::StScan)
    else $error("token left the chain outside a scan");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CntW'(TableEntries))
    else $error("entry total beyond table size");

  a_done_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && state_q == mltu_pkg::StIdle)
    else $error("result not presented after load");

endmodule

FILE: rtl/core/mltu_cell.sv
// ----------------------------------------------------------------------------
// mltu_cell
// One table entry; inspects the passing search token and hands it on.
// ----------------------------------------------------------------------------
module mltu_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [mltu_pkg::TimeW-1:0]            expiry_i,
  input  mltu_pkg::tok_t                        tok_i,
  input  mltu_pkg::wr_t                         wr_i,
  output mltu_pkg::tok_t                        tok_o
);

  localparam logic [mltu_pkg::SlotMaxW-1:0] MySlot = mltu_pkg::SlotMaxW'(Idx);

  logic                          valid_q, valid_d;
  logic [mltu_pkg::AddrW-1:0]    addr_q, addr_d;
  logic [mltu_pkg::TimeW-1:0]    last_q, last_d;
  logic [1:0]                    src_q, src_d;
  logic [mltu_pkg::SeenW-1:0]    cnt_q, cnt_d;
  mltu_pkg::tok_t                tok_q, tok_d;
  logic [mltu_pkg::TimeW-1:0]    age;

  always_comb begin
    valid_d = valid_q;
    addr_d  = addr_q;
    last_d  = last_q;
    src_d   = src_q;
    cnt_d   = cnt_q;
    tok_d   = tok_i;
    age     = tok_i.now - last_q;
    if (tok_i.active) begin
      if (tok_i.kind == mltu_pkg::KindSweep) begin
        if (valid_q && age > expiry_i) begin
          valid_d       = 1'b0;
          tok_d.removed = tok_i.removed + 1'b1;
        end
      end else begin
        if (valid_q && !tok_i.hit && addr_q == tok_i.addr) begin
          src_d  = (src_q != {1'b0, tok_i.src}) ? mltu_pkg::SrcBoth : src_q;
          cnt_d  = (cnt_q != mltu_pkg::SeenMax) ? cnt_q + 1'b1 : cnt_q;
          last_d = tok_i.now;
          tok_d.hit      = 1'b1;
          tok_d.hit_slot = MySlot;
          tok_d.hit_src  = src_d;
          tok_d.hit_cnt  = cnt_d;
        end
        if (!valid_q && !tok_i.free_found) begin
          tok_d.free_found = 1'b1;
          tok_d.free_slot  = MySlot;
        end
        // strict compare keeps ties on the lowest slot
        if (valid_q && (!tok_i.best_have || age > tok_i.best_age)) begin
          tok_d.best_have = 1'b1;
          tok_d.best_age  = age;
          tok_d.best_slot = MySlot;
        end
      end
    end
    if (wr_i.en && wr_i.slot == MySlot) begin
      valid_d = 1'b1;
      addr_d  = wr_i.addr;
      last_d  = wr_i.now;
      src_d   = {1'b0, wr_i.src};
      cnt_d   = mltu_pkg::SeenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    last_q <= last_d;
    src_q  <= src_d;
    cnt_q  <= cnt_d;
  end

  assign tok_o = tok_q;

endmodule
